@@ sv/ansi_escape_byte_parser_core_assert.svh @@
// assertion macros for the ansi escape byte parser core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ANSI_ESCAPE_BYTE_PARSER_CORE_ASSERT_SVH
`define ANSI_ESCAPE_BYTE_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define AEBP_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aebp assertion failed");
// clocked check that also holds during reset
`define AEBP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("aebp assertion failed");
`else
`define AEBP_ASSERT_CLK(lbl, prop)
`define AEBP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ sv/aebp_pkg.sv @@
// types and constants of the ansi escape byte parser
// no dependencies
package aebp_pkg;

  // parser states
  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_ESCAPE = 3'd1,
    ST_CSI    = 3'd2,
    ST_ESCSEQ = 3'd3,
    ST_STRING = 3'd4,
    ST_TERM   = 3'd5
  } aebp_state_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_BUSY = 2'd1,
    KIND_DONE = 2'd2
  } aebp_kind_e;

  // cursor commands
  typedef enum logic [2:0] {
    CUR_NONE      = 3'd0,
    CUR_UP        = 3'd1,
    CUR_DOWN      = 3'd2,
    CUR_RIGHT     = 3'd3,
    CUR_LEFT      = 3'd4,
    CUR_PAGE_UP   = 3'd5,
    CUR_PAGE_DOWN = 3'd6
  } aebp_cmd_e;

  // one result item
  typedef struct packed {
    aebp_kind_e kind;
    logic [7:0] ch;
    aebp_cmd_e  cmd;
  } aebp_result_t;

  // control bytes
  localparam logic [7:0] B_NUL   = 8'h00;
  localparam logic [7:0] B_BS    = 8'h08;
  localparam logic [7:0] B_CAN   = 8'h18;
  localparam logic [7:0] B_SUB   = 8'h1A;
  localparam logic [7:0] B_ESC   = 8'h1B;
  localparam logic [7:0] B_SPACE = 8'h20;
  localparam logic [7:0] B_CSI   = 8'h9B;
  localparam logic [7:0] B_ST    = 8'h9C;

  // printable bytes of interest
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_5        = 8'h35;
  localparam logic [7:0] CH_6        = 8'h36;
  localparam logic [7:0] CH_P        = 8'h50;
  localparam logic [7:0] CH_Q        = 8'h51;
  localparam logic [7:0] CH_R        = 8'h52;
  localparam logic [7:0] CH_X        = 8'h58;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_UNDER    = 8'h5F;

  // final byte bounds, exclusive, decimal
  localparam logic [7:0] FINAL_ESC_LO = 8'd57;
  localparam logic [7:0] FINAL_CSI_LO = 8'd64;
  localparam logic [7:0] FINAL_HI     = 8'd177;

endpackage

@@ sv/aebp_if.sv @@
// channel interfaces of the ansi escape byte parser
// no dependencies
interface aebp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface aebp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] char_out;
  logic [2:0] cursor_cmd;

  modport source (output valid, output result_kind, output char_out, output cursor_cmd,
                  input ready);
  modport sink   (input valid, input result_kind, input char_out, input cursor_cmd,
                  output ready);
endinterface

@@ sv/ansi_escape_byte_parser_core.sv @@
// top level of the ansi escape byte parser
// depends on aebp_pkg, aebp_if, aebp_parser and the assertion header
//
// Usage:
//   in_i  takes one received serial byte per request (valid/ready).
//   out_o gives exactly one result per byte: a plain character, busy while
//         a sequence is in progress, or done with a cursor command.
//   A byte is decoded in the cycle it is accepted and its result is registered
//   in the output register, or in the skid stage while out_o stalls.
//   Throughput is one byte per cycle while the skid stage is not full; the
//   parser state is updated by a single decode step at each accepted byte.
//   Behind the output register a one-entry skid stage keeps in_i open for one
//   more byte while a result waits; in_i.ready drops only while the skid
//   stage is full, and both entries drain in order once out_o.ready is high.
//   Reset returns the parser to the normal state with the escape store,
//   string length and string flag cleared, and empties both result entries.
//   ESC_DEPTH bounds the escape byte count, STRING_DEPTH the string length.
`include "ansi_escape_byte_parser_core_assert.svh"

module ansi_escape_byte_parser_core #(
  parameter int ESC_DEPTH    = 16,
  parameter int STRING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aebp_byte_if.sink   in_i,
  aebp_res_if.source  out_o
);

  logic                   accept;
  logic                   pop;
  aebp_pkg::aebp_result_t res;
  aebp_pkg::aebp_result_t out_q;
  aebp_pkg::aebp_result_t skid_q;
  logic                   out_valid_q;
  logic                   skid_valid_q;

  // handshakes
  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_valid_q && out_o.ready;

  // decode step with the parser state
  aebp_parser #(
    .ESC_DEPTH   (ESC_DEPTH),
    .STRING_DEPTH(STRING_DEPTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .data_byte_i(in_i.data_byte),
    .result_o   (res)
  );

  // output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_q.kind;
  assign out_o.char_out    = out_q.ch;
  assign out_o.cursor_cmd  = out_q.cmd;

  // checks
  `AEBP_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q)
  `AEBP_ASSERT_CLK(a_stall_fills_skid,
                   (accept && out_valid_q && !out_o.ready) |=> skid_valid_q)
  `AEBP_ASSERT_CLK(a_char_only_plain,
                   (out_valid_q && out_q.kind != aebp_pkg::KIND_CHAR) |-> (out_q.ch == 8'h00))
  `AEBP_ASSERT_CLK(a_cmd_only_done,
                   (out_valid_q && out_q.kind != aebp_pkg::KIND_DONE) |->
                   (out_q.cmd == aebp_pkg::CUR_NONE))

endmodule

@@ sv/aebp_parser.sv @@
// parser state registers and the per-byte decode step
// depends on aebp_pkg
module aebp_parser #(
  parameter int ESC_DEPTH    = 16,
  parameter int STRING_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  output aebp_pkg::aebp_result_t result_o
);

  localparam int EscW = $clog2(ESC_DEPTH + 1);
  localparam int StrW = $clog2(STRING_DEPTH + 1);

  aebp_pkg::aebp_state_e ps_q, ps_d;
  logic [EscW-1:0]       ei_q, ei_d;
  logic [7:0]            eb_q [4];
  logic [7:0]            eb_d [4];
  logic [StrW-1:0]       sl_q, sl_d;
  logic                  sa_q, sa_d;

  // decode one byte against the current state
  always_comb begin
    logic [7:0]  d;
    logic        do_str;
    logic [EscW-1:0] n;
    d       = data_byte_i;
    do_str  = 1'b0;
    n       = '0;
    ps_d    = ps_q;
    ei_d    = ei_q;
    eb_d    = eb_q;
    sl_d    = sl_q;
    sa_d    = sa_q;
    result_o.kind = aebp_pkg::KIND_BUSY;
    result_o.ch   = 8'h00;
    result_o.cmd  = aebp_pkg::CUR_NONE;

    if (ps_q == aebp_pkg::ST_NORMAL) begin
      // plain text, or the start of a sequence
      if (d == aebp_pkg::B_ESC) begin
        ps_d    = aebp_pkg::ST_ESCAPE;
        eb_d[0] = d;
        ei_d    = '0;
      end else if (d == aebp_pkg::B_CSI) begin
        ps_d    = aebp_pkg::ST_CSI;
        eb_d[0] = d;
        eb_d[1] = aebp_pkg::CH_LBRACKET;
        ei_d    = EscW'(1);
      end else begin
        result_o.kind = aebp_pkg::KIND_CHAR;
        result_o.ch   = d;
      end
    end else if (d < aebp_pkg::B_SPACE || d == aebp_pkg::B_CSI) begin
      // control byte inside a sequence
      priority if (d == aebp_pkg::B_CAN || d == aebp_pkg::B_SUB) begin
        ps_d = aebp_pkg::ST_NORMAL;
        sa_d = 1'b0;
        sl_d = '0;
      end else if (d == aebp_pkg::B_BS) begin
        // erase the previous sequence character
        if ((ps_q == aebp_pkg::ST_CSI || ps_q == aebp_pkg::ST_ESCSEQ) &&
            ei_q == EscW'(1)) begin
          ps_d = aebp_pkg::ST_ESCAPE;
          ei_d = '0;
        end else if (ps_q == aebp_pkg::ST_ESCAPE && ei_q == '0) begin
          ps_d = aebp_pkg::ST_NORMAL;
        end else if (ps_q == aebp_pkg::ST_TERM) begin
          ps_d = aebp_pkg::ST_STRING;
        end else if (ps_q == aebp_pkg::ST_STRING) begin
          if (sl_q != '0) begin
            sl_d = sl_q - StrW'(1);
          end else begin
            ps_d = aebp_pkg::ST_ESCAPE;
          end
        end else if (ei_q != '0) begin
          ei_d = ei_q - EscW'(1);
        end
      end else if (d == aebp_pkg::B_ESC) begin
        if (ps_q == aebp_pkg::ST_STRING) begin
          ps_d = aebp_pkg::ST_TERM;
        end else begin
          ps_d    = aebp_pkg::ST_ESCAPE;
          eb_d[0] = aebp_pkg::B_ESC;
          ei_d    = '0;
        end
      end else if (d == aebp_pkg::B_CSI) begin
        ps_d    = aebp_pkg::ST_CSI;
        eb_d[0] = aebp_pkg::B_CSI;
        eb_d[1] = aebp_pkg::CH_LBRACKET;
        ei_d    = EscW'(1);
      end else begin
        // nul stays busy, other controls pass through
        if (d != aebp_pkg::B_NUL) begin
          result_o.kind = aebp_pkg::KIND_CHAR;
          result_o.ch   = d;
        end
      end
    end else begin
      // store the byte while the escape store has room
      if (ps_q != aebp_pkg::ST_STRING && ps_q != aebp_pkg::ST_TERM &&
          ei_q < EscW'(ESC_DEPTH)) begin
        ei_d = ei_q + EscW'(1);
        if (ei_d < EscW'(4)) begin
          eb_d[ei_d[1:0]] = d;
        end
      end

      // state specific handling
      unique case (ps_q)
        aebp_pkg::ST_ESCAPE: begin
          if (d == aebp_pkg::CH_LBRACKET) begin
            ps_d = aebp_pkg::ST_CSI;
          end else if (d == aebp_pkg::CH_UNDER || d == aebp_pkg::CH_P ||
                       d == aebp_pkg::CH_Q || d == aebp_pkg::CH_R ||
                       d == aebp_pkg::CH_X || d == aebp_pkg::CH_CARET ||
                       d == aebp_pkg::CH_RBRACKET) begin
            ps_d = aebp_pkg::ST_STRING;
            sa_d = 1'b1;
            sl_d = '0;
          end else if (d > aebp_pkg::FINAL_ESC_LO && d < aebp_pkg::FINAL_HI) begin
            ps_d          = aebp_pkg::ST_NORMAL;
            result_o.kind = aebp_pkg::KIND_DONE;
          end else begin
            ps_d = aebp_pkg::ST_ESCSEQ;
          end
        end
        aebp_pkg::ST_ESCSEQ: begin
          if (d > aebp_pkg::FINAL_ESC_LO && d < aebp_pkg::FINAL_HI) begin
            ps_d          = aebp_pkg::ST_NORMAL;
            result_o.kind = aebp_pkg::KIND_DONE;
          end else begin
            do_str = 1'b1;
          end
        end
        aebp_pkg::ST_CSI: begin
          if (d > aebp_pkg::FINAL_CSI_LO && d < aebp_pkg::FINAL_HI) begin
            ps_d          = aebp_pkg::ST_NORMAL;
            result_o.kind = aebp_pkg::KIND_DONE;
          end else begin
            do_str = 1'b1;
          end
        end
        aebp_pkg::ST_STRING: begin
          do_str = 1'b1;
        end
        aebp_pkg::ST_TERM: begin
          if (d == aebp_pkg::CH_BSLASH) begin
            ps_d = aebp_pkg::ST_NORMAL;
            sa_d = 1'b0;
          end else begin
            ps_d = aebp_pkg::ST_STRING;
            if (({1'b0, sl_q} + (StrW+1)'(1)) < (StrW+1)'(STRING_DEPTH)) begin
              sl_d = sl_q + StrW'(2);
            end
          end
        end
        default: begin
        end
      endcase

      // string body byte, shared by several states
      if (do_str) begin
        if (d == aebp_pkg::B_ESC) begin
          ps_d = aebp_pkg::ST_TERM;
        end else if (d == aebp_pkg::B_ST) begin
          ps_d = aebp_pkg::ST_NORMAL;
          sa_d = 1'b0;
        end else if (sa_q) begin
          if (sl_q < StrW'(STRING_DEPTH)) begin
            sl_d = sl_q + StrW'(1);
          end else begin
            sa_d = 1'b0;
            sl_d = '0;
            ps_d = aebp_pkg::ST_NORMAL;
          end
        end
      end

      // translate the finished sequence into a cursor command
      if (result_o.kind == aebp_pkg::KIND_DONE) begin
        n    = ei_d;
        ei_d = '0;
        if ((n == EscW'(2) || n == EscW'(3)) && eb_d[0] == aebp_pkg::B_ESC &&
            eb_d[1] == aebp_pkg::CH_LBRACKET) begin
          if (n == EscW'(2)) begin
            priority if (eb_d[2] == aebp_pkg::CH_A) result_o.cmd = aebp_pkg::CUR_UP;
            else if (eb_d[2] == aebp_pkg::CH_B) result_o.cmd = aebp_pkg::CUR_DOWN;
            else if (eb_d[2] == aebp_pkg::CH_C) result_o.cmd = aebp_pkg::CUR_RIGHT;
            else if (eb_d[2] == aebp_pkg::CH_D) result_o.cmd = aebp_pkg::CUR_LEFT;
            else result_o.cmd = aebp_pkg::CUR_NONE;
          end else if (eb_d[3] == aebp_pkg::CH_TILDE) begin
            if (eb_d[2] == aebp_pkg::CH_5) begin
              result_o.cmd = aebp_pkg::CUR_PAGE_UP;
            end else if (eb_d[2] == aebp_pkg::CH_6) begin
              result_o.cmd = aebp_pkg::CUR_PAGE_DOWN;
            end
          end
        end
      end
    end
  end

  // state registers, updated once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= aebp_pkg::ST_NORMAL;
      ei_q <= '0;
      eb_q <= '{default: 8'h00};
      sl_q <= '0;
      sa_q <= 1'b0;
    end else if (step_i) begin
      ps_q <= ps_d;
      ei_q <= ei_d;
      eb_q <= eb_d;
      sl_q <= sl_d;
      sa_q <= sa_d;
    end
  end

endmodule
